// ----- hw/rtl/jde_pkg.sv -----
// Package for the Jacobian distortion energy block: field widths, chain
// lengths, register codes and reset values. No dependencies.
`default_nettype none
package jde_pkg;

   localparam int unsigned FRAC_BITS_DEFAULT    = 24;
   localparam int unsigned ENERGY_WIDTH_DEFAULT = 48;

   localparam int unsigned J_WIDTH       = 32;
   localparam int unsigned SIGMA_WIDTH   = 36;
   localparam int unsigned PENALTY_WIDTH = 48;
   localparam int unsigned KIND_WIDTH    = 2;
   localparam int unsigned CSR_DATA_W    = 64;
   localparam int unsigned CSR_ADDR_W    = 4;

   // Sum of the four squared entries, and the radicands of q and r.
   localparam int unsigned SQ_SUM_W = 2 * J_WIDTH + 1;
   localparam int unsigned MAG_W    = J_WIDTH + 1;
   localparam int unsigned X_W      = 2 * MAG_W;

   localparam int unsigned SQ_STEPS = X_W / 2;
   localparam int unsigned SQ_RES_W = SQ_STEPS;
   localparam int unsigned SQ_REM_W = SQ_RES_W + 2;

   localparam int unsigned DIV_D_W   = 63;
   localparam int unsigned DIV_Q_W   = 64;
   localparam int unsigned DIV_STEPS = DIV_Q_W;

   localparam int unsigned SIG_W     = 35;
   localparam int unsigned MAG_S_W   = 34;
   localparam int unsigned ARAP_SUM_W = 2 * MAG_S_W + 1;
   localparam int unsigned VAL_W     = 66;

   localparam logic [PENALTY_WIDTH-1:0] PENALTY_RESET = 48'h989680000000;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_DIRICHLET,
      KIND_SYM_DIRICHLET,
      KIND_ARAP,
      KIND_ASAP
   } energy_kind_type;

   typedef enum logic {
      REG_ENERGY_KIND,
      REG_FLIP_PENALTY
   } reg_index_type;

endpackage
`default_nettype wire

// ----- hw/rtl/jacobian_distortion_energy.sv -----
// Top level of the Jacobian distortion energy block: input stages, the
// square root and divider cell chains, energy selection and output buffer.
// Depends on jde_pkg, jde_sqrt_cell, jde_div_cell and jde_delay.
//
// Usage: each item on the req_ channel carries one 2x2 Jacobian in signed
// fixed point. Each item yields exactly one result on the rsp_ channel: the
// selected energy, both signed singular values and a saturation flag.
// The energy kind and the flip penalty are set through the csr_ port,
// which the user must write only while no item is in flight; the block itself does not enforce this.
// Throughput is one item per clock while req_stall is low. After the
// accepting edge an item passes four input stages, 128 divider cells (two
// chained 64-bit quotients for the symmetric Dirichlet term), a selection
// stage and the output register that drives rsp_valid; the first stage loads at acceptance.
// The square root chains (33 cells) run alongside.
// While the receiver stalls, a result waits in the output register and the
// pipeline keeps taking items until the skid register also holds one; then
// req_stall rises until the receiver takes a result.
// Reset clears all valid flags and sets the configuration registers to their defaults.
`default_nettype none
module jacobian_distortion_energy #(
   parameter int unsigned FRAC_BITS    = jde_pkg::FRAC_BITS_DEFAULT,
   parameter int unsigned ENERGY_WIDTH = jde_pkg::ENERGY_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [jde_pkg::J_WIDTH-1:0]    req_j00,
   input  wire logic signed [jde_pkg::J_WIDTH-1:0]    req_j10,
   input  wire logic signed [jde_pkg::J_WIDTH-1:0]    req_j01,
   input  wire logic signed [jde_pkg::J_WIDTH-1:0]    req_j11,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic             [ENERGY_WIDTH-1:0]        rsp_energy,
   output logic signed      [jde_pkg::SIGMA_WIDTH-1:0] rsp_sigma_one,
   output logic signed      [jde_pkg::SIGMA_WIDTH-1:0] rsp_sigma_two,
   output logic                                       rsp_saturated,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic        [jde_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic        [jde_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic             [jde_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                       csr_pready
);
   import jde_pkg::*;

   localparam int unsigned SQF_W      = SQ_SUM_W - FRAC_BITS;
   localparam int unsigned X2F_W      = X_W - FRAC_BITS;
   localparam int unsigned ARAPF_W    = ARAP_SUM_W - FRAC_BITS;
   localparam int unsigned NW         = SQ_SUM_W + 3 * FRAC_BITS;
   localparam int unsigned PIPE_DEPTH = 2 * DIV_STEPS + 5;
   localparam int unsigned ARAP_DELAY = 2 * DIV_STEPS - SQ_STEPS - 3;
   localparam int unsigned SIDE_W     = SQF_W + X2F_W + 3;
   localparam int unsigned LATE_W     = 2 * SIG_W + ARAPF_W;

   // Configuration registers.
   energy_kind_type          kind_ff;
   logic [PENALTY_WIDTH-1:0] pen_ff;
   reg_index_type            csr_index;

   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_DIRICHLET;
         pen_ff  <= PENALTY_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_index)
            REG_ENERGY_KIND:  kind_ff <= energy_kind_type'(csr_pwdata[KIND_WIDTH-1:0]);
            REG_FLIP_PENALTY: pen_ff  <= csr_pwdata[PENALTY_WIDTH-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ENERGY_KIND:  csr_prdata = CSR_DATA_W'(kind_ff);
         REG_FLIP_PENALTY: csr_prdata = CSR_DATA_W'(pen_ff);
      endcase
   end

   // Flow control.
   logic                  adv;
   logic                  skid_valid_ff;
   logic                  main_valid_ff;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  arrive;

   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign arrive    = adv && vld_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   // Stage 1: input registers.
   logic signed [J_WIDTH-1:0] j00_ff, j10_ff, j01_ff, j11_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         j00_ff <= req_j00;
         j10_ff <= req_j10;
         j01_ff <= req_j01;
         j11_ff <= req_j11;
      end
   end

   // Stage 2: products and half-sum magnitudes.
   logic signed [J_WIDTH:0]     a1, b1, a2, b2;
   logic signed [2*J_WIDTH-1:0] s00, s10, s01, s11, pa, pb;
   logic [2*J_WIDTH-1:0] s00_ff, s10_ff, s01_ff, s11_ff, pa_ff, pb_ff;
   logic [MAG_W-1:0]     ma1_ff, mb1_ff, ma2_ff, mb2_ff;

   always_comb begin
      a1  = {j00_ff[J_WIDTH-1], j00_ff} + {j11_ff[J_WIDTH-1], j11_ff};
      b1  = {j10_ff[J_WIDTH-1], j10_ff} - {j01_ff[J_WIDTH-1], j01_ff};
      a2  = {j00_ff[J_WIDTH-1], j00_ff} - {j11_ff[J_WIDTH-1], j11_ff};
      b2  = {j10_ff[J_WIDTH-1], j10_ff} + {j01_ff[J_WIDTH-1], j01_ff};
      s00 = j00_ff * j00_ff;
      s10 = j10_ff * j10_ff;
      s01 = j01_ff * j01_ff;
      s11 = j11_ff * j11_ff;
      pa  = j00_ff * j11_ff;
      pb  = j01_ff * j10_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s00_ff <= s00;
         s10_ff <= s10;
         s01_ff <= s01;
         s11_ff <= s11;
         pa_ff  <= pa;
         pb_ff  <= pb;
         ma1_ff <= a1[J_WIDTH] ? MAG_W'(-a1) : MAG_W'(a1);
         mb1_ff <= b1[J_WIDTH] ? MAG_W'(-b1) : MAG_W'(b1);
         ma2_ff <= a2[J_WIDTH] ? MAG_W'(-a2) : MAG_W'(a2);
         mb2_ff <= b2[J_WIDTH] ? MAG_W'(-b2) : MAG_W'(b2);
      end
   end

   // Stage 3: squares of the half-sums, sum of squares, determinant.
   logic [X_W-1:0]       sqa1_ff, sqb1_ff, sqa2_ff, sqb2_ff;
   logic [SQ_SUM_W-1:0]  sq_ff;
   logic [2*J_WIDTH-1:0] det_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sqa1_ff <= ma1_ff * ma1_ff;
         sqb1_ff <= mb1_ff * mb1_ff;
         sqa2_ff <= ma2_ff * ma2_ff;
         sqb2_ff <= mb2_ff * mb2_ff;
         sq_ff   <= SQ_SUM_W'(s00_ff) + SQ_SUM_W'(s10_ff)
                  + SQ_SUM_W'(s01_ff) + SQ_SUM_W'(s11_ff);
         det_ff  <= pa_ff - pb_ff;
      end
   end

   // Stage 4: radicands and the divider set-up.
   logic [NW-1:0]      wide_n;
   logic [NW-1:0]      wide_hi;
   logic [X_W-1:0]     x1_ff, x2_ff;
   logic [SQF_W-1:0]   sqf_ff;
   logic [X2F_W-1:0]   x2f_ff;
   logic [X_W-1:0]     x2_in;
   logic [DIV_D_W-1:0] rem0_ff, d_ff;
   logic [DIV_Q_W-1:0] low_ff;
   logic               over_ff, detneg_ff, detzero_ff;

   always_comb begin
      wide_n  = NW'(sq_ff) << (3 * FRAC_BITS);
      wide_hi = wide_n >> DIV_Q_W;
      x2_in   = sqa2_ff + sqb2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff      <= sqa1_ff + sqb1_ff;
         x2_ff      <= x2_in;
         sqf_ff     <= SQF_W'(sq_ff >> FRAC_BITS);
         x2f_ff     <= X2F_W'(x2_in >> FRAC_BITS);
         rem0_ff    <= wide_hi[DIV_D_W-1:0];
         low_ff     <= wide_n[DIV_Q_W-1:0];
         d_ff       <= det_ff[DIV_D_W-1:0];
         over_ff    <= wide_hi >= NW'(det_ff[DIV_D_W-1:0]);
         detneg_ff  <= det_ff[2*J_WIDTH-1];
         detzero_ff <= det_ff == '0;
      end
   end

   // Square root chains for q and r.
   logic [X_W-1:0]      qx  [SQ_STEPS+1];
   logic [SQ_REM_W-1:0] qrm [SQ_STEPS+1];
   logic [SQ_RES_W-1:0] qrs [SQ_STEPS+1];
   logic [X_W-1:0]      rx  [SQ_STEPS+1];
   logic [SQ_REM_W-1:0] rrm [SQ_STEPS+1];
   logic [SQ_RES_W-1:0] rrs [SQ_STEPS+1];

   assign qx[0]  = x1_ff;
   assign qrm[0] = '0;
   assign qrs[0] = '0;
   assign rx[0]  = x2_ff;
   assign rrm[0] = '0;
   assign rrs[0] = '0;

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
      jde_sqrt_cell u_q (
         .clock  (clock),
         .enable (adv),
         .x_i    (qx[i]),
         .rem_i  (qrm[i]),
         .res_i  (qrs[i]),
         .x_o    (qx[i+1]),
         .rem_o  (qrm[i+1]),
         .res_o  (qrs[i+1])
      );
      jde_sqrt_cell u_r (
         .clock  (clock),
         .enable (adv),
         .x_i    (rx[i]),
         .rem_i  (rrm[i]),
         .res_i  (rrs[i]),
         .x_o    (rx[i+1]),
         .rem_o  (rrm[i+1]),
         .res_o  (rrs[i+1])
      );
   end

   // Divider chain: first the quotient by d, then that quotient by d again.
   logic [DIV_D_W-1:0] drm  [2*DIV_STEPS+1];
   logic [DIV_Q_W-1:0] dwd  [2*DIV_STEPS+1];
   logic [DIV_D_W-1:0] ddv  [2*DIV_STEPS+1];

   assign drm[0] = rem0_ff;
   assign dwd[0] = low_ff;
   assign ddv[0] = d_ff;

   for (genvar i = 0; i < 2 * DIV_STEPS; i++) begin : g_div
      logic [DIV_D_W-1:0] rem_start;
      assign rem_start = (i == DIV_STEPS) ? '0 : drm[i];
      jde_div_cell u_cell (
         .clock  (clock),
         .enable (adv),
         .rem_i  (rem_start),
         .word_i (dwd[i]),
         .d_i    (ddv[i]),
         .rem_o  (drm[i+1]),
         .word_o (dwd[i+1]),
         .d_o    (ddv[i+1])
      );
   end

   // ARAP stages after the square roots.
   logic [SQ_RES_W-2:0]      q_half, r_half;
   logic signed [SIG_W-1:0]  s1, s2, ds1, ds2, one;
   logic signed [SIG_W-1:0]  s1_a_ff, s2_a_ff, s1_b_ff, s2_b_ff, s1_c_ff, s2_c_ff;
   logic [MAG_S_W-1:0]       m1_ff, m2_ff;
   logic [2*MAG_S_W-1:0]     sqm1_ff, sqm2_ff;
   logic [ARAPF_W-1:0]       arapf_ff;
   logic [ARAP_SUM_W-1:0]    arap_sum;

   always_comb begin
      q_half   = qrs[SQ_STEPS][SQ_RES_W-1:1];
      r_half   = rrs[SQ_STEPS][SQ_RES_W-1:1];
      one      = SIG_W'(1) << FRAC_BITS;
      s1       = SIG_W'(q_half) + SIG_W'(r_half);
      s2       = SIG_W'(q_half) - SIG_W'(r_half);
      ds1      = s1 - one;
      ds2      = s2 - one;
      arap_sum = ARAP_SUM_W'(sqm1_ff) + ARAP_SUM_W'(sqm2_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_a_ff  <= s1;
         s2_a_ff  <= s2;
         m1_ff    <= ds1[SIG_W-1] ? MAG_S_W'(-ds1) : MAG_S_W'(ds1);
         m2_ff    <= ds2[SIG_W-1] ? MAG_S_W'(-ds2) : MAG_S_W'(ds2);
         s1_b_ff  <= s1_a_ff;
         s2_b_ff  <= s2_a_ff;
         sqm1_ff  <= m1_ff * m1_ff;
         sqm2_ff  <= m2_ff * m2_ff;
         s1_c_ff  <= s1_b_ff;
         s2_c_ff  <= s2_b_ff;
         arapf_ff <= ARAPF_W'(arap_sum >> FRAC_BITS);
      end
   end

   // Side values travel beside the chains.
   logic [SIDE_W-1:0]      side_out;
   logic [LATE_W-1:0]      late_out;
   logic [SQF_W-1:0]       sqf_d;
   logic [X2F_W-1:0]       x2f_d;
   logic                   detneg_d, detzero_d, over_d;
   logic signed [SIG_W-1:0] s1_d, s2_d;
   logic [ARAPF_W-1:0]     arapf_d;

   jde_delay #(.WIDTH(SIDE_W), .DEPTH(2 * DIV_STEPS)) u_side (
      .clock  (clock),
      .enable (adv),
      .din    ({sqf_ff, x2f_ff, detneg_ff, detzero_ff, over_ff}),
      .dout   (side_out)
   );

   jde_delay #(.WIDTH(LATE_W), .DEPTH(ARAP_DELAY)) u_late (
      .clock  (clock),
      .enable (adv),
      .din    ({s1_c_ff, s2_c_ff, arapf_ff}),
      .dout   (late_out)
   );

   assign {sqf_d, x2f_d, detneg_d, detzero_d, over_d} = side_out;
   assign {s1_d, s2_d, arapf_d} = late_out;

   // Selection and clipping.
   logic [VAL_W-1:0]        cand;
   logic                    pen_mode, force_max, clipped;
   logic [ENERGY_WIDTH-1:0] energy_in;
   logic                    sat_in;
   logic [ENERGY_WIDTH-1:0] energy_p_ff;
   logic                    sat_p_ff;
   logic signed [SIG_W-1:0] sig1_p_ff, sig2_p_ff;

   always_comb begin
      pen_mode  = 1'b0;
      force_max = 1'b0;
      cand      = VAL_W'(sqf_d);
      unique case (kind_ff)
         KIND_DIRICHLET: cand = VAL_W'(sqf_d);
         KIND_SYM_DIRICHLET: begin
            priority if (detneg_d) begin
               pen_mode = 1'b1;
               cand     = VAL_W'(pen_ff);
            end else if (detzero_d || over_d) begin
               force_max = 1'b1;
            end else begin
               cand = VAL_W'(sqf_d) + VAL_W'(dwd[2*DIV_STEPS]);
            end
         end
         KIND_ARAP: cand = VAL_W'(arapf_d);
         KIND_ASAP: cand = VAL_W'(x2f_d);
      endcase
      clipped   = |cand[VAL_W-1:ENERGY_WIDTH];
      energy_in = (force_max || clipped) ? '1 : cand[ENERGY_WIDTH-1:0];
      sat_in    = force_max || (clipped && !pen_mode);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         energy_p_ff <= energy_in;
         sat_p_ff    <= sat_in;
         sig1_p_ff   <= s1_d;
         sig2_p_ff   <= s2_d;
      end
   end

   // Output register and skid register.
   logic [ENERGY_WIDTH-1:0] main_energy_ff, skid_energy_ff;
   logic                    main_sat_ff, skid_sat_ff;
   logic signed [SIG_W-1:0] main_s1_ff, main_s2_ff, skid_s1_ff, skid_s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= arrive;
         end
      end else if (arrive) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!main_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            main_energy_ff <= skid_energy_ff;
            main_sat_ff    <= skid_sat_ff;
            main_s1_ff     <= skid_s1_ff;
            main_s2_ff     <= skid_s2_ff;
         end else begin
            main_energy_ff <= energy_p_ff;
            main_sat_ff    <= sat_p_ff;
            main_s1_ff     <= sig1_p_ff;
            main_s2_ff     <= sig2_p_ff;
         end
      end else if (arrive) begin
         skid_energy_ff <= energy_p_ff;
         skid_sat_ff    <= sat_p_ff;
         skid_s1_ff     <= sig1_p_ff;
         skid_s2_ff     <= sig2_p_ff;
      end
   end

   assign rsp_valid     = main_valid_ff;
   assign rsp_energy    = main_energy_ff;
   assign rsp_saturated = main_sat_ff;
   assign rsp_sigma_one = {main_s1_ff[SIG_W-1], main_s1_ff};
   assign rsp_sigma_two = {main_s2_ff[SIG_W-1], main_s2_ff};
endmodule
`default_nettype wire

// ----- hw/rtl/jde_sqrt_cell.sv -----
// One digit step of the integer square root chain: two radicand bits in,
// one root bit out, registered. Depends on jde_pkg.
`default_nettype none
module jde_sqrt_cell (
   input  wire logic                         clock,
   input  wire logic                         enable,
   input  wire logic [jde_pkg::X_W-1:0]      x_i,
   input  wire logic [jde_pkg::SQ_REM_W-1:0] rem_i,
   input  wire logic [jde_pkg::SQ_RES_W-1:0] res_i,
   output logic      [jde_pkg::X_W-1:0]      x_o,
   output logic      [jde_pkg::SQ_REM_W-1:0] rem_o,
   output logic      [jde_pkg::SQ_RES_W-1:0] res_o
);
   import jde_pkg::*;

   logic [SQ_REM_W+1:0] full;
   logic [SQ_REM_W+1:0] trial;
   logic [SQ_REM_W+1:0] diff;
   logic [X_W-1:0]      x_in;
   logic [SQ_REM_W-1:0] rem_in;
   logic [SQ_RES_W-1:0] res_in;
   logic [X_W-1:0]      x_ff;
   logic [SQ_REM_W-1:0] rem_ff;
   logic [SQ_RES_W-1:0] res_ff;

   always_comb begin
      full  = {rem_i, x_i[X_W-1 -: 2]};
      trial = (SQ_REM_W + 2)'({res_i, 2'b01});
      diff  = full - trial;
      x_in  = x_i << 2;
      if (full >= trial) begin
         rem_in = diff[SQ_REM_W-1:0];
         res_in = {res_i[SQ_RES_W-2:0], 1'b1};
      end else begin
         rem_in = full[SQ_REM_W-1:0];
         res_in = {res_i[SQ_RES_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff   <= x_in;
         rem_ff <= rem_in;
         res_ff <= res_in;
      end
   end

   assign x_o   = x_ff;
   assign rem_o = rem_ff;
   assign res_o = res_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/jde_div_cell.sv -----
// One restoring division step: shifts a dividend bit into the remainder
// and a quotient bit into the dividend word, registered. Depends on jde_pkg.
`default_nettype none
module jde_div_cell (
   input  wire logic                        clock,
   input  wire logic                        enable,
   input  wire logic [jde_pkg::DIV_D_W-1:0] rem_i,
   input  wire logic [jde_pkg::DIV_Q_W-1:0] word_i,
   input  wire logic [jde_pkg::DIV_D_W-1:0] d_i,
   output logic      [jde_pkg::DIV_D_W-1:0] rem_o,
   output logic      [jde_pkg::DIV_Q_W-1:0] word_o,
   output logic      [jde_pkg::DIV_D_W-1:0] d_o
);
   import jde_pkg::*;

   logic [DIV_D_W:0]   full;
   logic [DIV_D_W:0]   diff;
   logic [DIV_D_W-1:0] rem_in;
   logic [DIV_Q_W-1:0] word_in;
   logic [DIV_D_W-1:0] rem_ff;
   logic [DIV_Q_W-1:0] word_ff;
   logic [DIV_D_W-1:0] d_ff;

   always_comb begin
      full = {rem_i, word_i[DIV_Q_W-1]};
      diff = full - {1'b0, d_i};
      if (full >= {1'b0, d_i}) begin
         rem_in  = diff[DIV_D_W-1:0];
         word_in = {word_i[DIV_Q_W-2:0], 1'b1};
      end else begin
         rem_in  = full[DIV_D_W-1:0];
         word_in = {word_i[DIV_Q_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         word_ff <= word_in;
         d_ff    <= d_i;
      end
   end

   assign rem_o  = rem_ff;
   assign word_o = word_ff;
   assign d_o    = d_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/jde_delay.sv -----
// Shift line that carries side values alongside the cell chains so that
// they meet the chain outputs. No dependencies.
`default_nettype none
module jde_delay #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (enable) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];
endmodule
`default_nettype wire
